[src/rbp_pkg.sv]
// Shared types and constants for the RTCP report block parser.
// No dependencies; every other file in src/ refers to this package by scoped names.
package rbp_pkg;

  localparam int LENGTH_BITS_DEFAULT = 16;
  localparam int OFFSET_BITS         = 16;
  localparam int PACKET_BITS         = 19;

  localparam logic [7:0] TYPE_SR    = 8'd200;
  localparam logic [7:0] TYPE_RR    = 8'd201;
  localparam logic [7:0] COUNT_MASK = 8'h1F;

  localparam int BLOCK_LEN     = 24;
  localparam int MIN_DATAGRAM  = 8;
  localparam int SR_FIRST_BYTE = 28;
  localparam int RR_FIRST_BYTE = 8;
  localparam int HEADER_BYTES  = 4;
  localparam int SSRC_END_BYTE = 7;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int FILL_BITS  = $clog2(FIFO_DEPTH + 1);

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] datagram_length;
    logic        end_of_datagram;
  } item_t;

  typedef struct packed {
    logic               result_kind;
    logic [31:0]        origin_ssrc;
    logic [31:0]        source_ssrc;
    logic [7:0]         loss_fraction;
    logic signed [23:0] loss_count;
    logic [31:0]        highest_sequence;
    logic [31:0]        arrival_jitter;
    logic [31:0]        last_report_stamp;
    logic [31:0]        delay_since_report;
    logic [7:0]         block_total;
    logic               last_result;
  } result_t;

  // Results produced by one parsed byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic                 room;
    logic [FILL_BITS-1:0] fill;
  } fifo_status_t;

endpackage

[src/rbp_parser.sv]
// Input register and per-byte compound packet walk with report block capture.
// Depends on rbp_pkg; feeds rbp_result_fifo through an rbp_pkg::push_t bundle.
module rbp_parser #(
  parameter int LENGTH_BITS = rbp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  rbp_pkg::item_t  item,
  input  logic            room,
  output rbp_pkg::push_t  push
);

  localparam int OB = rbp_pkg::OFFSET_BITS;
  localparam int PB = rbp_pkg::PACKET_BITS;

  logic           stg_valid;
  rbp_pkg::item_t stg;
  logic           advance;

  logic [LENGTH_BITS-1:0] held_length, held_length_next;
  logic [OB-1:0]          datagram_offset, datagram_offset_next;
  logic [PB-1:0]          packet_offset, packet_offset_next;
  logic [PB-1:0]          packet_bytes, packet_bytes_next;
  logic [7:0]             pkt_type, pkt_type_next;
  logic [4:0]             rpt_count, rpt_count_next;
  logic [4:0]             blocks_in_packet, blocks_in_packet_next;
  logic [4:0]             block_byte_index, block_byte_index_next;
  logic [31:0]            current_reporter, current_reporter_next;
  logic [7:0]             block_counter, block_counter_next;
  logic                   walk_stopped, walk_stopped_next;

  logic [7:0] block_bytes [rbp_pkg::BLOCK_LEN];

  logic [OB-1:0] hl_ext;
  logic          walk;
  logic [PB-1:0] p_inc;
  logic [PB-1:0] first_block_byte;
  logic [16:0]   len_plus_one;
  logic [PB-1:0] new_packet_bytes;
  logic [PB-1:0] span;
  logic          is_report;
  logic          step_offset;
  logic [7:0]    masked_count;
  logic          bb_we;
  logic [4:0]    bb_idx;
  logic          emit_rec;
  logic [7:0]    total_now;
  rbp_pkg::result_t rec, summ;

  assign item_ready = !stg_valid || room;
  assign advance    = stg_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (item_ready) begin
      stg_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      stg <= item;
    end
  end

  always_comb begin
    held_length_next      = held_length;
    datagram_offset_next  = datagram_offset;
    packet_offset_next    = packet_offset;
    packet_bytes_next     = packet_bytes;
    pkt_type_next         = pkt_type;
    rpt_count_next        = rpt_count;
    blocks_in_packet_next = blocks_in_packet;
    block_byte_index_next = block_byte_index;
    current_reporter_next = current_reporter;
    block_counter_next    = block_counter;
    walk_stopped_next     = walk_stopped;
    bb_we       = 1'b0;
    bb_idx      = block_byte_index;
    emit_rec    = 1'b0;
    step_offset = 1'b1;

    // Sample the length on the first byte of a datagram.
    if (datagram_offset == '0) begin
      held_length_next  = stg.datagram_length[LENGTH_BITS-1:0];
      walk_stopped_next = OB'(held_length_next) < OB'(rbp_pkg::MIN_DATAGRAM);
    end
    hl_ext = OB'(held_length_next);
    walk   = !walk_stopped_next && (datagram_offset < hl_ext);

    p_inc            = packet_offset + PB'(1);
    is_report        = (pkt_type == rbp_pkg::TYPE_SR) || (pkt_type == rbp_pkg::TYPE_RR);
    first_block_byte = (pkt_type == rbp_pkg::TYPE_SR) ? PB'(rbp_pkg::SR_FIRST_BYTE)
                                                      : PB'(rbp_pkg::RR_FIRST_BYTE);
    len_plus_one     = {1'b0, packet_bytes[15:8], stg.data_byte} + 17'd1;
    new_packet_bytes = {len_plus_one, 2'b00};
    span             = PB'(datagram_offset) - PB'(3) + new_packet_bytes;
    masked_count     = stg.data_byte & rbp_pkg::COUNT_MASK;

    if (walk) begin
      if (packet_offset == PB'(0)) begin
        rpt_count_next        = masked_count[4:0];
        blocks_in_packet_next = '0;
        block_byte_index_next = '0;
      end else if (packet_offset == PB'(1)) begin
        pkt_type_next = stg.data_byte;
      end else if (packet_offset == PB'(2)) begin
        packet_bytes_next = {3'b000, stg.data_byte, 8'h00};
      end else if (packet_offset == PB'(3)) begin
        packet_bytes_next = new_packet_bytes;
        // Stop the walk for the rest of the datagram on overrun.
        if (span > PB'(hl_ext)) begin
          walk_stopped_next = 1'b1;
          step_offset       = 1'b0;
        end
      end else if (is_report) begin
        if (packet_offset < PB'(rbp_pkg::SSRC_END_BYTE + 1)) begin
          bb_we  = 1'b1;
          bb_idx = {3'b000, packet_offset[1:0]};
          if (packet_offset == PB'(rbp_pkg::SSRC_END_BYTE)) begin
            current_reporter_next = {block_bytes[0], block_bytes[1], block_bytes[2],
                                     stg.data_byte};
          end
        end
        if (packet_offset >= first_block_byte && blocks_in_packet < rpt_count) begin
          bb_we  = 1'b1;
          bb_idx = block_byte_index;
          if (block_byte_index == 5'(rbp_pkg::BLOCK_LEN - 1)) begin
            emit_rec              = 1'b1;
            block_byte_index_next = '0;
            blocks_in_packet_next = blocks_in_packet + 5'd1;
            if (block_counter != 8'hFF) begin
              block_counter_next = block_counter + 8'd1;
            end
          end else begin
            block_byte_index_next = block_byte_index + 5'd1;
          end
        end
      end
      if (step_offset) begin
        if (p_inc >= PB'(rbp_pkg::HEADER_BYTES) && p_inc >= packet_bytes_next) begin
          packet_offset_next = '0;
        end else begin
          packet_offset_next = p_inc;
        end
      end
    end

    if (datagram_offset != {OB{1'b1}}) begin
      datagram_offset_next = datagram_offset + OB'(1);
    end

    total_now = block_counter_next;

    // Clear per-datagram state on the final byte.
    if (stg.end_of_datagram) begin
      datagram_offset_next  = '0;
      packet_offset_next    = '0;
      packet_bytes_next     = '0;
      pkt_type_next         = '0;
      rpt_count_next        = '0;
      blocks_in_packet_next = '0;
      block_byte_index_next = '0;
      block_counter_next    = '0;
      walk_stopped_next     = 1'b0;
    end
  end

  always_comb begin
    rec                    = '0;
    rec.result_kind        = rbp_pkg::KIND_RECORD;
    rec.origin_ssrc        = current_reporter;
    rec.source_ssrc        = {block_bytes[0], block_bytes[1], block_bytes[2], block_bytes[3]};
    rec.loss_fraction      = block_bytes[4];
    rec.loss_count         = $signed({block_bytes[5], block_bytes[6], block_bytes[7]});
    rec.highest_sequence   = {block_bytes[8], block_bytes[9], block_bytes[10], block_bytes[11]};
    rec.arrival_jitter     = {block_bytes[12], block_bytes[13], block_bytes[14],
                              block_bytes[15]};
    rec.last_report_stamp  = {block_bytes[16], block_bytes[17], block_bytes[18],
                              block_bytes[19]};
    rec.delay_since_report = {block_bytes[20], block_bytes[21], block_bytes[22],
                              stg.data_byte};
    rec.last_result        = !stg.end_of_datagram;

    summ               = '0;
    summ.result_kind   = rbp_pkg::KIND_SUMMARY;
    summ.origin_ssrc   = current_reporter_next;
    summ.block_total   = total_now;
    summ.last_result   = 1'b1;

    push        = '0;
    push.second = summ;
    if (emit_rec) begin
      push.first = rec;
    end else begin
      push.first = summ;
    end
    if (advance) begin
      push.count = 2'(emit_rec) + 2'(stg.end_of_datagram);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_length      <= '0;
      datagram_offset  <= '0;
      packet_offset    <= '0;
      packet_bytes     <= '0;
      pkt_type         <= '0;
      rpt_count        <= '0;
      blocks_in_packet <= '0;
      block_byte_index <= '0;
      current_reporter <= '0;
      block_counter    <= '0;
      walk_stopped     <= 1'b0;
    end else if (advance) begin
      held_length      <= held_length_next;
      datagram_offset  <= datagram_offset_next;
      packet_offset    <= packet_offset_next;
      packet_bytes     <= packet_bytes_next;
      pkt_type         <= pkt_type_next;
      rpt_count        <= rpt_count_next;
      blocks_in_packet <= blocks_in_packet_next;
      block_byte_index <= block_byte_index_next;
      current_reporter <= current_reporter_next;
      block_counter    <= block_counter_next;
      walk_stopped     <= walk_stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && bb_we) begin
      block_bytes[bb_idx] <= stg.data_byte;
    end
  end

endmodule

[src/rbp_result_fifo.sv]
// Small result queue: takes up to two results per cycle, delivers one beat per cycle while result_ready is high.
// Depends on rbp_pkg for result_t, push_t, fifo_status_t and FIFO_DEPTH.
module rbp_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  rbp_pkg::push_t        push,
  output rbp_pkg::fifo_status_t status,
  output logic                  result_valid,
  input  logic                  result_ready,
  output rbp_pkg::result_t      result
);

  localparam int PW = rbp_pkg::PTR_BITS;
  localparam int FW = rbp_pkg::FILL_BITS;

  rbp_pkg::result_t entries [rbp_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [FW-1:0] fill;
  logic          pop;

  assign result_valid = fill != '0;
  assign result       = entries[rd_ptr];
  assign pop          = result_valid && result_ready;
  assign status.fill  = fill;
  // Room for a full pair of results from the next byte.
  assign status.room  = fill <= FW'(rbp_pkg::FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      fill <= fill + FW'(push.count) - FW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PW'(1)] <= push.second;
    end
  end

endmodule

[src/rtcp_report_block_parser.sv]
// Top level of the RTCP compound datagram report block parser.
// Depends on rbp_pkg, rbp_parser and rbp_result_fifo.
//
//   channel | signals                           | payload type
//   --------+-----------------------------------+------------------
//   input   | item_valid, item_ready, item      | rbp_pkg::item_t
//   output  | result_valid, result_ready, result| rbp_pkg::result_t
//
// One byte is taken per cycle while item_ready is high; it passes through the input register
// and then the result queue before its results are offered. A byte that completes a report
// block on the final byte of a datagram yields two results, which drain through the four-entry result queue.
// item_ready drops only while the queue holds more than two results.
// Reset (rst, synchronous) clears the walk state, the held reporter SSRC and the queue.
module rtcp_report_block_parser #(
  parameter int LENGTH_BITS = rbp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  rbp_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output rbp_pkg::result_t result
);

  rbp_pkg::push_t        push;
  rbp_pkg::fifo_status_t fifo_status;

  rbp_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .room       (fifo_status.room),
    .push       (push)
  );

  rbp_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .status       (fifo_status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_status.fill <= rbp_pkg::FILL_BITS'(rbp_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> fifo_status.room)
    else $error("results pushed without queue room");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> !fifo_status.room)
    else $error("input stalled while queue has room");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.first.result_kind == rbp_pkg::KIND_RECORD &&
      push.second.result_kind == rbp_pkg::KIND_SUMMARY &&
      !push.first.last_result && push.second.last_result)
    else $error("record and summary pair out of order");
`endif

endmodule

[dv/rtcp_report_block_parser_tb.sv]
// Self-checking testbench for rtcp_report_block_parser: byte-stream stimulus of compound
// RTCP datagrams, a scoreboard class that predicts report block records and summaries.
// Depends on rbp_pkg and the RTL top level in src/.
module rtcp_report_block_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int        LEN_BITS        = rbp_pkg::LENGTH_BITS_DEFAULT;
  localparam bit [15:0] LEN_MASK        = 16'((32'd1 << LEN_BITS) - 1);
  localparam bit [7:0]  TYPE_SDES       = 8'd202;
  localparam bit [7:0]  TYPE_BYE        = 8'd203;
  localparam bit [7:0]  TYPE_APP        = 8'd204;
  localparam int        RANDOM_ITEMS    = 1150;
  localparam int        MAX_GAP         = 12;
  localparam int        LONG_HOLD       = 300;
  localparam int        DRAIN_CYCLES    = 40;
  localparam int        PRESSURE_BLOCKS = 8;
  localparam int        TIMEOUT_NS      = 10_000_000;

  class report_scoreboard;
    bit [15:0] held_length;
    bit [15:0] datagram_offset;
    bit [18:0] packet_offset;
    bit [18:0] packet_bytes;
    bit [7:0]  pkt_type;
    bit [4:0]  rpt_count;
    bit [4:0]  blocks_in_packet;
    bit [4:0]  block_byte_index;
    bit [7:0]  block_bytes[rbp_pkg::BLOCK_LEN];
    bit [31:0] current_reporter;
    bit [7:0]  block_counter;
    bit        walk_stopped;
    rbp_pkg::result_t expected_results[$];
    int        failures;

    function new();
      held_length = '0;
      current_reporter = '0;
      failures = 0;
      foreach (block_bytes[k]) block_bytes[k] = '0;
      clear_datagram();
    endfunction

    function void clear_datagram();
      datagram_offset = '0;
      packet_offset = '0;
      packet_bytes = '0;
      pkt_type = '0;
      rpt_count = '0;
      blocks_in_packet = '0;
      block_byte_index = '0;
      block_counter = '0;
      walk_stopped = 1'b0;
    endfunction

    function bit [31:0] word_at(int base);
      return {block_bytes[base], block_bytes[base+1], block_bytes[base+2], block_bytes[base+3]};
    endfunction

    // Advance the datagram walk by one accepted byte and queue what it yields.
    function void note_byte(rbp_pkg::item_t beat);
      rbp_pkg::result_t found[$];
      rbp_pkg::result_t r;
      bit [15:0] idx;
      bit [18:0] p;
      bit [18:0] first;
      bit        advance;
      if (datagram_offset == 0) begin
        held_length = beat.datagram_length & LEN_MASK;
        walk_stopped = held_length < rbp_pkg::MIN_DATAGRAM;
      end
      idx = datagram_offset;
      if (!walk_stopped && idx < held_length) begin
        p = packet_offset;
        advance = 1'b1;
        if (p == 0) begin
          rpt_count = 5'(beat.data_byte & rbp_pkg::COUNT_MASK);
          blocks_in_packet = '0;
          block_byte_index = '0;
        end else if (p == 1) begin
          pkt_type = beat.data_byte;
        end else if (p == 2) begin
          packet_bytes = {3'b000, beat.data_byte, 8'h00};
        end else if (p == 3) begin
          packet_bytes = 19'((int'({packet_bytes[15:8], beat.data_byte}) + 1) * 4);
          // stop the walk for good when this packet runs past the datagram
          if (int'(idx) - 3 + int'(packet_bytes) > int'(held_length)) begin
            walk_stopped = 1'b1;
            advance = 1'b0;
          end
        end else if (pkt_type == rbp_pkg::TYPE_SR || pkt_type == rbp_pkg::TYPE_RR) begin
          first = (pkt_type == rbp_pkg::TYPE_SR) ? 19'(rbp_pkg::SR_FIRST_BYTE)
                                                 : 19'(rbp_pkg::RR_FIRST_BYTE);
          if (p <= rbp_pkg::SSRC_END_BYTE) begin
            block_bytes[p[1:0]] = beat.data_byte;
            if (p == rbp_pkg::SSRC_END_BYTE) current_reporter = word_at(0);
          end
          if (p >= first && blocks_in_packet < rpt_count) begin
            if (block_byte_index < rbp_pkg::BLOCK_LEN) begin
              block_bytes[block_byte_index] = beat.data_byte;
            end
            block_byte_index++;
            if (block_byte_index >= rbp_pkg::BLOCK_LEN) begin
              r = '0;
              r.result_kind = rbp_pkg::KIND_RECORD;
              r.origin_ssrc = current_reporter;
              r.source_ssrc = word_at(0);
              r.loss_fraction = block_bytes[4];
              r.loss_count = {block_bytes[5], block_bytes[6], block_bytes[7]};
              r.highest_sequence = word_at(8);
              r.arrival_jitter = word_at(12);
              r.last_report_stamp = word_at(16);
              r.delay_since_report = word_at(20);
              found.insert(found.size(), r);
              block_byte_index = '0;
              blocks_in_packet++;
              if (block_counter != 8'hFF) block_counter++;
            end
          end
        end
        if (advance) begin
          p++;
          if (p >= rbp_pkg::HEADER_BYTES && p >= packet_bytes) p = '0;
          packet_offset = p;
        end
      end
      if (datagram_offset != 16'hFFFF) datagram_offset++;
      if (beat.end_of_datagram) begin
        r = '0;
        r.result_kind = rbp_pkg::KIND_SUMMARY;
        r.origin_ssrc = current_reporter;
        r.block_total = block_counter;
        found.insert(found.size(), r);
        clear_datagram();
      end
      foreach (found[k]) begin
        r = found[k];
        r.last_result = (k == found.size() - 1);
        expected_results.insert(expected_results.size(), r);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(rbp_pkg::result_t got);
      rbp_pkg::result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h", $time, got);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
      compare_field("origin_ssrc", want.origin_ssrc, got.origin_ssrc);
      compare_field("source_ssrc", want.source_ssrc, got.source_ssrc);
      compare_field("loss_fraction", 32'(want.loss_fraction), 32'(got.loss_fraction));
      compare_field("loss_count", 32'(want.loss_count), 32'(got.loss_count));
      compare_field("highest_sequence", want.highest_sequence, got.highest_sequence);
      compare_field("arrival_jitter", want.arrival_jitter, got.arrival_jitter);
      compare_field("last_report_stamp", want.last_report_stamp, got.last_report_stamp);
      compare_field("delay_since_report", want.delay_since_report, got.delay_since_report);
      compare_field("block_total", 32'(want.block_total), 32'(got.block_total));
      compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_ready;
  rbp_pkg::item_t   item;
  logic             result_valid;
  logic             result_ready;
  rbp_pkg::result_t result;

  report_scoreboard sb;
  bit [7:0]         dgram[$];
  int               sent_bytes;
  int               hold_requests;

  rtcp_report_block_parser #(
    .LENGTH_BITS(LEN_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  function automatic void put_byte(input bit [7:0] b);
    dgram.insert(dgram.size(), b);
  endfunction

  function automatic void put_header(input bit [4:0] count, input bit [7:0] ptype,
                                     input bit [15:0] words);
    put_byte({3'($urandom), count});
    put_byte(ptype);
    put_byte(words[15:8]);
    put_byte(words[7:0]);
  endfunction

  // Bias words toward field extremes so block fields hit all-zero, all-one and sign edges.
  function automatic void put_words(input int count);
    bit [31:0] w;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: w = 32'h0000_0000;
        1: w = 32'hFFFF_FFFF;
        2: w = 32'h0080_0000;
        3: w = 32'h007F_FFFF;
        default: w = $urandom;
      endcase
      put_byte(w[31:24]);
      put_byte(w[23:16]);
      put_byte(w[15:8]);
      put_byte(w[7:0]);
    end
  endfunction

  function automatic void put_report(input bit [7:0] ptype, input int blocks,
                                     input int claimed, input int pad_words);
    int body;
    body = ((ptype == rbp_pkg::TYPE_SR) ? rbp_pkg::SR_FIRST_BYTE : rbp_pkg::RR_FIRST_BYTE)
           + rbp_pkg::BLOCK_LEN * blocks + 4 * pad_words;
    put_header(5'(claimed), ptype, 16'(body / 4 - 1));
    put_words((body - rbp_pkg::HEADER_BYTES) / 4);
  endfunction

  function automatic void build_compound(output bit [15:0] declared);
    int       total;
    int       blocks;
    int       claimed;
    int       words;
    bit [7:0] ptype;
    dgram.delete();
    repeat ($urandom_range(1, 3)) begin
      blocks = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      ptype = $urandom_range(0, 1) ? rbp_pkg::TYPE_SR : rbp_pkg::TYPE_RR;
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          case ($urandom_range(0, 3))
            0: ptype = TYPE_SDES;
            1: ptype = TYPE_BYE;
            2: ptype = TYPE_APP;
            default: ptype = 8'($urandom);
          endcase
          words = $urandom_range(0, 5);
          put_header(5'($urandom), ptype, 16'(words));
          put_words(words);
        end
        3: put_header(5'($urandom), ptype, 16'd0);
        4, 5: begin
          // claim more blocks than the packet holds
          claimed = blocks + $urandom_range(1, 3);
          put_report(ptype, blocks, claimed, $urandom_range(0, 1));
        end
        6, 7, 8, 9, 10, 11: put_report(rbp_pkg::TYPE_RR, blocks, blocks,
                                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
        default: put_report(rbp_pkg::TYPE_SR, blocks, blocks,
                            ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      endcase
    end
    total = dgram.size();
    case ($urandom_range(0, 19))
      0: begin
        dgram.delete();
        repeat ($urandom_range(1, 7)) put_byte(8'($urandom));
        declared = 16'(dgram.size());
      end
      1: declared = 16'($urandom_range(0, total - 1));
      2: declared = 16'($urandom_range(total + 1, 65535));
      3: begin
        dgram[2] = 8'($urandom);
        dgram[3] = 8'($urandom);
        declared = 16'(total);
      end
      default: declared = 16'(total);
    endcase
  endfunction

  task automatic send_byte(input rbp_pkg::item_t beat, input int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= beat;
    do @(posedge clk); while (!item_ready);
    sb.note_byte(beat);
  endtask

  task automatic send_datagram(input bit [15:0] declared, input bit burst);
    rbp_pkg::item_t beat;
    foreach (dgram[k]) begin
      beat.data_byte = dgram[k];
      beat.datagram_length = (k == 0) ? declared : 16'($urandom);
      beat.end_of_datagram = (k == dgram.size() - 1);
      send_byte(beat, burst ? 0 : $urandom_range(0, MAX_GAP));
      sent_bytes++;
    end
  endtask

  initial begin : result_sink
    int wait_cycles;
    int quiet_left;
    int holds_served;
    quiet_left = 0;
    holds_served = 0;
    result_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (holds_served != hold_requests) begin
        holds_served++;
        wait_cycles = LONG_HOLD;
      end else if ($urandom_range(0, 59) == 0) begin
        wait_cycles = LONG_HOLD;
      end else if (quiet_left > 0) begin
        quiet_left--;
        wait_cycles = 0;
      end else if ($urandom_range(0, 24) == 0) begin
        quiet_left = 30;
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, MAX_GAP);
      end
      if (wait_cycles > 0) begin
        result_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      sb.check_result(result);
    end
  end

  initial begin : byte_source
    bit [15:0] declared;
    sb = new();
    hold_requests = 0;
    sent_bytes = 0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // one byte of a maximum-length datagram, then an early end
    dgram.delete();
    put_byte(8'hFF);
    send_datagram(16'hFFFF, 1'b1);
    // runt datagram: summary only
    dgram = {8'h81, rbp_pkg::TYPE_RR, 8'h00, 8'h01, 8'hAA};
    send_datagram(16'd5, 1'b0);
    // zero length: every byte lies past the end
    dgram = {8'h00, 8'h00};
    send_datagram(16'd0, 1'b0);
    // header-only receiver report, then a sender report that overruns
    dgram = {8'h81, rbp_pkg::TYPE_RR, 8'h00, 8'h00, 8'h9F, rbp_pkg::TYPE_SR, 8'hFF, 8'hFF};
    send_datagram(16'd8, 1'b1);
    // receiver report with SSRC and no blocks
    dgram = {8'h80, rbp_pkg::TYPE_RR, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_datagram(16'd8, 1'b0);

    // hold the receiver off while a many-block report streams in, filling the queue
    dgram.delete();
    put_report(rbp_pkg::TYPE_RR, PRESSURE_BLOCKS, PRESSURE_BLOCKS, 0);
    hold_requests++;
    send_datagram(16'(dgram.size()), 1'b1);

    while (sent_bytes < RANDOM_ITEMS) begin
      build_compound(declared);
      send_datagram(declared, $urandom_range(0, 3) == 0);
    end
    item_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
